### design/asgr_pkg.sv
// Shared types, byte codes and the color map for the SGR attribute parser.
`timescale 1ns / 1ps
`default_nettype none

package asgr_pkg;

   localparam int unsigned BYTE_W = 8;

   localparam logic [BYTE_W-1:0] ATTR_RESET   = 8'h0F;
   localparam logic [BYTE_W-1:0] CHAR_NONE    = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_ESC     = 8'h1B;
   localparam logic [BYTE_W-1:0] CHAR_LBRACK  = 8'h5B;
   localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_ONE     = 8'h31;
   localparam logic [BYTE_W-1:0] CHAR_THREE   = 8'h33;
   localparam logic [BYTE_W-1:0] CHAR_FOUR    = 8'h34;
   localparam logic [BYTE_W-1:0] CHAR_SEVEN   = 8'h37;
   localparam logic [BYTE_W-1:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [BYTE_W-1:0] CHAR_SEMI    = 8'h3B;
   localparam logic [BYTE_W-1:0] CHAR_M       = 8'h6D;

   localparam logic [BYTE_W-1:0] BRIGHT_BIT   = 8'h08;
   localparam logic [BYTE_W-1:0] FG_KEEP_MASK = 8'hF8;
   localparam logic [BYTE_W-1:0] BG_KEEP_MASK = 8'h0F;

   // register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic CSR_IDX_DEFAULT_ATTR = 1'b0;

   typedef enum logic [6:0] {
      PS_WAIT_ESC     = 7'b0000001,
      PS_WAIT_BRACKET = 7'b0000010,
      PS_VALUE        = 7'b0000100,
      PS_FG           = 7'b0001000,
      PS_BG           = 7'b0010000,
      PS_EQUALS       = 7'b0100000,
      PS_END_VALUE    = 7'b1000000
   } parse_state_type;

   // ANSI color number to VGA color order
   function automatic logic [2:0] vga_color(input logic [2:0] ansi);
      logic [2:0] vga;
      case (ansi)
         3'd0: vga = 3'd0;
         3'd1: vga = 3'd4;
         3'd2: vga = 3'd2;
         3'd3: vga = 3'd6;
         3'd4: vga = 3'd1;
         3'd5: vga = 3'd5;
         3'd6: vga = 3'd3;
         3'd7: vga = 3'd7;
         default: vga = 3'd0;
      endcase
      return vga;
   endfunction

endpackage

`default_nettype wire

### design/asgr_csr.sv
// APB-style register file holding the default attribute.
`timescale 1ns / 1ps
`default_nettype none

module asgr_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [asgr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [31:0]                         pwdata,
   output logic      [31:0]                         prdata,
   output logic                                     pready,
   output logic      [asgr_pkg::BYTE_W-1:0]         default_attr
);

   logic [asgr_pkg::BYTE_W-1:0] default_attr_ff;
   logic [asgr_pkg::BYTE_W-1:0] default_attr_in;
   logic                        wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite
                   && (paddr[2] == asgr_pkg::CSR_IDX_DEFAULT_ATTR);

   always_comb begin
      default_attr_in = default_attr_ff;
      if (wr_hit) begin
         default_attr_in = pwdata[asgr_pkg::BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_attr_ff <= asgr_pkg::ATTR_RESET;
      end else begin
         default_attr_ff <= default_attr_in;
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == asgr_pkg::CSR_IDX_DEFAULT_ATTR) begin
         prdata = {24'd0, default_attr_ff};
      end
   end

   assign default_attr = default_attr_ff;

endmodule

`default_nettype wire

### design/asgr_parser.sv
// Escape sequence state machine with current and pending attribute registers.
`timescale 1ns / 1ps
`default_nettype none

module asgr_parser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [asgr_pkg::BYTE_W-1:0] char_in,
   input  wire logic [asgr_pkg::BYTE_W-1:0] default_attr,
   output logic      [asgr_pkg::BYTE_W-1:0] attr_out,
   output logic      [asgr_pkg::BYTE_W-1:0] char_out
);

   asgr_pkg::parse_state_type   state_ff, state_in;
   logic [asgr_pkg::BYTE_W-1:0] current_ff, current_in;
   logic [asgr_pkg::BYTE_W-1:0] pending_ff, pending_in;
   logic                        is_digit;
   logic [2:0]                  color;

   assign is_digit = (char_in >= asgr_pkg::CHAR_ZERO) && (char_in <= asgr_pkg::CHAR_SEVEN);
   assign color    = asgr_pkg::vga_color(char_in[2:0]);
   assign attr_out = current_ff;

   always_comb begin
      state_in   = state_ff;
      current_in = current_ff;
      pending_in = pending_ff;
      char_out   = asgr_pkg::CHAR_NONE;
      case (state_ff)
         asgr_pkg::PS_WAIT_ESC: begin
            if (char_in == asgr_pkg::CHAR_ESC) begin
               state_in = asgr_pkg::PS_WAIT_BRACKET;
            end else begin
               char_out = char_in;
            end
         end
         asgr_pkg::PS_WAIT_BRACKET: begin
            if (char_in == asgr_pkg::CHAR_LBRACK) begin
               state_in = asgr_pkg::PS_VALUE;
            end else begin
               state_in = asgr_pkg::PS_WAIT_ESC;
               char_out = char_in;
            end
         end
         asgr_pkg::PS_VALUE: begin
            if (char_in == asgr_pkg::CHAR_THREE) begin
               state_in = asgr_pkg::PS_FG;
            end else if (char_in == asgr_pkg::CHAR_FOUR) begin
               state_in = asgr_pkg::PS_BG;
            end else if (char_in == asgr_pkg::CHAR_ZERO) begin
               state_in   = asgr_pkg::PS_END_VALUE;
               pending_in = default_attr;
            end else if (char_in == asgr_pkg::CHAR_ONE) begin
               state_in   = asgr_pkg::PS_END_VALUE;
               pending_in = pending_ff | asgr_pkg::BRIGHT_BIT;
            end else if (char_in == asgr_pkg::CHAR_EQUALS) begin
               state_in = asgr_pkg::PS_EQUALS;
            end else begin
               state_in   = asgr_pkg::PS_WAIT_ESC;
               pending_in = current_ff;
               char_out   = char_in;
            end
         end
         asgr_pkg::PS_FG: begin
            if (is_digit) begin
               state_in   = asgr_pkg::PS_END_VALUE;
               pending_in = (pending_ff & asgr_pkg::FG_KEEP_MASK) | {5'd0, color};
            end else begin
               state_in   = asgr_pkg::PS_WAIT_ESC;
               pending_in = current_ff;
               char_out   = char_in;
            end
         end
         asgr_pkg::PS_BG: begin
            if (is_digit) begin
               state_in   = asgr_pkg::PS_END_VALUE;
               pending_in = (pending_ff & asgr_pkg::BG_KEEP_MASK) | {1'b0, color, 4'd0};
            end else begin
               state_in   = asgr_pkg::PS_WAIT_ESC;
               pending_in = current_ff;
               char_out   = char_in;
            end
         end
         asgr_pkg::PS_EQUALS: begin
            if (char_in == asgr_pkg::CHAR_ONE) begin
               state_in   = asgr_pkg::PS_END_VALUE;
               pending_in = pending_ff & ~asgr_pkg::BRIGHT_BIT;
            end else begin
               state_in   = asgr_pkg::PS_WAIT_ESC;
               pending_in = current_ff;
               char_out   = char_in;
            end
         end
         asgr_pkg::PS_END_VALUE: begin
            if (char_in == asgr_pkg::CHAR_SEMI) begin
               state_in = asgr_pkg::PS_VALUE;
            end else if (char_in == asgr_pkg::CHAR_M) begin
               state_in   = asgr_pkg::PS_WAIT_ESC;
               current_in = pending_ff;
            end else begin
               state_in   = asgr_pkg::PS_WAIT_ESC;
               pending_in = current_ff;
               char_out   = char_in;
            end
         end
         default: begin
            state_in = asgr_pkg::PS_WAIT_ESC;
            char_out = char_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= asgr_pkg::PS_WAIT_ESC;
         current_ff <= asgr_pkg::ATTR_RESET;
         pending_ff <= asgr_pkg::ATTR_RESET;
      end else if (step) begin
         state_ff   <= state_in;
         current_ff <= current_in;
         pending_ff <= pending_in;
      end
   end

   // a completed sequence copies the pending attribute into the current one
   assert property (@(posedge clock) disable iff (reset)
      step && state_ff == asgr_pkg::PS_END_VALUE && char_in == asgr_pkg::CHAR_M
      |=> current_ff == $past(pending_ff))
      else $error("current attribute not committed on sequence end");

   // a broken sequence drops pending changes
   assert property (@(posedge clock) disable iff (reset)
      step && state_ff != asgr_pkg::PS_WAIT_ESC && char_out != asgr_pkg::CHAR_NONE
      |=> state_ff == asgr_pkg::PS_WAIT_ESC && pending_ff == current_ff)
      else $error("aborted sequence left pending attribute");

   assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("parser state not one-hot");

endmodule

`default_nettype wire

### design/ansi_sgr_text_attribute_parser_unit.sv
// Top level of the ANSI SGR text attribute parser: channel registers and wiring.
//
// Usage:
//   req channel carries one character byte per transaction (req_char_in).
//   rsp channel returns one transaction per request: rsp_attribute is the
//   attribute in effect before that byte, rsp_char_out the byte to display
//   or 0 when the parser consumed it.
//   An input register holds each accepted byte; the parser state machine
//   between it and the output register handles one byte per cycle while
//   the output register is free. A taken byte waits in the input register;
//   its result is then registered in the output register that drives rsp.
//   Throughput: one transaction per cycle while rsp_ready stays high.
//   When rsp_ready is low the output register holds, the input register
//   keeps one more byte, then req_ready drops until rsp drains.
//   Reset (synchronous, active high) empties both registers, returns the
//   parser to waiting for ESC and sets the default, current and pending
//   attributes to 0x0F. A write of default_attribute (APB, address 0)
//   takes effect at the next SGR code 0.
`timescale 1ns / 1ps
`default_nettype none

module ansi_sgr_text_attribute_parser_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [asgr_pkg::BYTE_W-1:0]         req_char_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [asgr_pkg::BYTE_W-1:0]         rsp_attribute,
   output logic      [asgr_pkg::BYTE_W-1:0]         rsp_char_out,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [asgr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [31:0]                         pwdata,
   output logic      [31:0]                         prdata,
   output logic                                     pready
);

   logic                        in_valid_ff, in_valid_in;
   logic [asgr_pkg::BYTE_W-1:0] in_char_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [asgr_pkg::BYTE_W-1:0] rsp_attr_ff;
   logic [asgr_pkg::BYTE_W-1:0] rsp_char_ff;
   logic [asgr_pkg::BYTE_W-1:0] default_attr;
   logic [asgr_pkg::BYTE_W-1:0] step_attr;
   logic [asgr_pkg::BYTE_W-1:0] step_char;
   logic                        out_free;
   logic                        advance;
   logic                        req_take;

   asgr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .default_attr (default_attr)
   );

   asgr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .char_in      (in_char_ff),
      .default_attr (default_attr),
      .attr_out     (step_attr),
      .char_out     (step_char)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_in;
      end
      if (advance) begin
         rsp_attr_ff <= step_attr;
         rsp_char_ff <= step_char;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_attribute = rsp_attr_ff;
   assign rsp_char_out  = rsp_char_ff;

   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("parsed transaction lost before output register");

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_char_ff))
      else $error("held input byte changed while output stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !advance)
      else $error("parser stepped while output register full");

endmodule

`default_nettype wire
